[design/ihex_enc_pkg.sv]
// shared constants, command codes and hex digit helper for the hex record encoder
`default_nettype none

package ihex_enc_pkg;

	// default record length in data bytes
	localparam int RECORD_BYTES_DEF = 16;
	// most characters one command may produce
	localparam int OUT_LIMIT = 56;
	// width of the per-command character counter
	localparam int CNT_W = 6;

	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	// 'A' minus ten
	localparam logic [7:0] CHAR_A_OFS   = 8'h37;
	localparam logic [7:0] TYPE_DATA    = 8'h00;
	localparam logic [7:0] TYPE_EOF     = 8'h01;

	typedef enum logic [1:0] {
		CMD_DATA = 2'd0,
		CMD_ADDR = 2'd1,
		CMD_END  = 2'd2
	} cmd_t;

	// uppercase hex digit for one nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ext;
		ext = {4'h0, nib};
		if (nib < 4'd10) begin
			return CHAR_ZERO + ext;
		end else begin
			return CHAR_A_OFS + ext;
		end
	endfunction

endpackage

`default_nettype wire

[design/ihex_enc_cmd_if.sv]
// command channel: one beat per data byte, address load or end of file
`default_nettype none

interface ihex_enc_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [7:0]  data_byte;
	logic [15:0] load_address;

	modport source (output valid, output cmd, output data_byte, output load_address,
		input ready);
	modport sink (input valid, input cmd, input data_byte, input load_address,
		output ready);
endinterface

`default_nettype wire

[design/ihex_enc_char_if.sv]
// character channel: one ascii character per beat
`default_nettype none

interface ihex_enc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       last_char;

	modport source (output valid, output out_char, output last_char, input ready);
	modport sink (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

[design/intel_hex_record_encoder.sv]
// top level of the hex record encoder: command intake, record sequencer, output register
`default_nettype none

// Turns a stream of commands into hex record text, one ascii character per beat on
// char_ch. A data byte command (cmd 0) writes the byte into the record buffer; once
// RECORD_BYTES bytes are pending a data record goes out:
// ':' count addr_hi addr_lo "00" data... checksum '\n', all bytes as two uppercase
// hex digits, checksum the two's complement of the byte sum. An address command
// (cmd 1) first flushes pending bytes as a shorter record, then loads the address.
// An end command (cmd 2) flushes, then sends the end record ":00" addr "01" checksum
// '\n' at the advanced address. cmd 3 does nothing. The address advances by each
// record's byte count and wraps at 16 bits. last_char marks the final character of a
// command; a command never yields more than 56 characters, extra ones are dropped.
// A command that sends nothing leaves the sequencer idle. A command that sends text
// yields 12 + 2*n characters for a record of n bytes, paced by the single output
// character register and held while the receiver stalls. cmd_ch.ready is high only
// while the sequencer is idle; it returns at the same edge at which the final character
// enters the output register, unless characters were dropped, so the next command
// is taken while that character still waits to be read.
// The buffer is a synchronous memory; the sequencer fetches each data byte one
// character ahead of its first hex digit. Writes happen only at intake and reads
// only while a record is sent, so the two never touch the same entry at once.
module intel_hex_record_encoder #(
	parameter int RECORD_BYTES = ihex_enc_pkg::RECORD_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ihex_enc_cmd_if.sink     cmd_ch,
	ihex_enc_char_if.source  char_ch
);
	import ihex_enc_pkg::*;

	// buffer index width and byte count width
	localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
	localparam int CW = $clog2(RECORD_BYTES + 1);
	localparam logic [CW-1:0]    REC_FULL = CW'(RECORD_BYTES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OUT_LIMIT - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_COLON,
		S_HI,
		S_LO,
		S_NL
	} state_t;

	// which byte of the record is being sent
	typedef enum logic [2:0] {
		F_COUNT,
		F_AHI,
		F_ALO,
		F_TYPE,
		F_DATA,
		F_CSUM
	} field_t;

	state_t            state_q;
	field_t            field_q;
	logic [AW-1:0]     di_q;        // data byte index within the record
	logic [CW-1:0]     count_q;     // pending bytes in the buffer
	logic [CW-1:0]     rec_n_q;     // byte count of the record in flight
	logic              rec_eof_q;   // record in flight is the end record
	logic [15:0]       addr_q;
	logic [15:0]       addr_pend_q;
	logic              load_pend_q; // load addr_pend_q after the flush record
	logic              end_pend_q;  // send the end record after the flush record
	logic [7:0]        sum_q;
	logic [CNT_W-1:0]  cnt_q;       // characters produced for this command
	logic              drop_q;      // character limit reached, keep state moving only

	logic              ovalid_q;
	logic [7:0]        ochar_q;
	logic              olast_q;

	logic              cmd_fire;
	logic              adv;
	logic [7:0]        byte_d;
	logic [7:0]        char_d;
	logic              last_d;
	logic              last_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [7:0]        rd_data;

	assign cmd_ch.ready = (state_q == S_IDLE);
	assign cmd_fire     = cmd_ch.valid && cmd_ch.ready;

	// sequencer moves when the output register can take a character, or freely
	// once characters are being dropped
	assign adv = (state_q != S_IDLE) && (drop_q || !ovalid_q || char_ch.ready);

	assign last_data = ((CW'(di_q) + CW'(1)) == rec_n_q);

	// byte value of the current field
	always_comb begin
		case (field_q)
			F_COUNT: byte_d = 8'(rec_n_q);
			F_AHI:   byte_d = addr_q[15:8];
			F_ALO:   byte_d = addr_q[7:0];
			F_TYPE:  byte_d = rec_eof_q ? TYPE_EOF : TYPE_DATA;
			F_DATA:  byte_d = rd_data;
			F_CSUM:  byte_d = 8'(8'h00 - sum_q);
			default: byte_d = 8'h00;
		endcase
	end

	always_comb begin
		case (state_q)
			S_COLON: char_d = CHAR_COLON;
			S_HI:    char_d = hex_char(byte_d[7:4]);
			S_LO:    char_d = hex_char(byte_d[3:0]);
			S_NL:    char_d = CHAR_NEWLINE;
			default: char_d = CHAR_NEWLINE;
		endcase
	end

	// final newline of the command, or the last character the limit lets through
	assign last_d = ((state_q == S_NL) && !end_pend_q) || (cnt_q == CNT_LAST);

	// prefetch the next data byte while the low digit of the previous byte goes out
	assign rd_en   = adv && (state_q == S_LO);
	assign rd_addr = (field_q == F_TYPE) ? '0 : di_q + AW'(1);

	ihex_enc_buf #(
		.DEPTH (RECORD_BYTES),
		.AW    (AW)
	) u_buf (
		.clk     (clk),
		.wr_en   (cmd_fire && (cmd_ch.cmd == CMD_DATA)),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (cmd_ch.data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			field_q     <= F_COUNT;
			di_q        <= '0;
			count_q     <= '0;
			rec_n_q     <= '0;
			rec_eof_q   <= 1'b0;
			addr_q      <= '0;
			load_pend_q <= 1'b0;
			end_pend_q  <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			drop_q      <= 1'b0;
			ovalid_q    <= 1'b0;
			olast_q     <= 1'b0;
		end else begin
			if (char_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						cnt_q  <= '0;
						drop_q <= 1'b0;
						case (cmd_ch.cmd)
							CMD_DATA: begin
								if ((count_q + CW'(1)) == REC_FULL) begin
									// buffer full: send it
									rec_n_q   <= REC_FULL;
									rec_eof_q <= 1'b0;
									state_q   <= S_COLON;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_ADDR: begin
								if (count_q != '0) begin
									rec_n_q     <= count_q;
									rec_eof_q   <= 1'b0;
									addr_pend_q <= cmd_ch.load_address;
									load_pend_q <= 1'b1;
									state_q     <= S_COLON;
								end else begin
									addr_q <= cmd_ch.load_address;
								end
							end
							CMD_END: begin
								if (count_q != '0) begin
									rec_n_q    <= count_q;
									rec_eof_q  <= 1'b0;
									end_pend_q <= 1'b1;
								end else begin
									rec_n_q   <= '0;
									rec_eof_q <= 1'b1;
								end
								state_q <= S_COLON;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					if (adv) begin
						if (!drop_q) begin
							ovalid_q <= 1'b1;
							ochar_q  <= char_d;
							olast_q  <= last_d;
						end
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == CNT_LAST) begin
							drop_q <= 1'b1;
						end
						case (state_q)
							S_COLON: begin
								field_q <= F_COUNT;
								sum_q   <= '0;
								state_q <= S_HI;
							end
							S_HI: begin
								state_q <= S_LO;
							end
							S_LO: begin
								sum_q   <= sum_q + byte_d;
								state_q <= S_HI;
								case (field_q)
									F_COUNT: field_q <= F_AHI;
									F_AHI:   field_q <= F_ALO;
									F_ALO:   field_q <= F_TYPE;
									F_TYPE: begin
										di_q    <= '0;
										field_q <= (rec_n_q == '0) ? F_CSUM : F_DATA;
									end
									F_DATA: begin
										if (last_data) begin
											field_q <= F_CSUM;
										end else begin
											di_q <= di_q + AW'(1);
										end
									end
									F_CSUM:  state_q <= S_NL;
									default: field_q <= F_COUNT;
								endcase
							end
							S_NL: begin
								count_q <= '0;
								if (end_pend_q) begin
									// flush done, end record follows at the advanced address
									addr_q     <= addr_q + 16'(rec_n_q);
									end_pend_q <= 1'b0;
									rec_n_q    <= '0;
									rec_eof_q  <= 1'b1;
									state_q    <= S_COLON;
								end else begin
									state_q <= S_IDLE;
									if (load_pend_q) begin
										addr_q      <= addr_pend_q;
										load_pend_q <= 1'b0;
									end else begin
										addr_q <= addr_q + 16'(rec_n_q);
									end
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
			endcase
		end
	end

	assign char_ch.valid     = ovalid_q;
	assign char_ch.out_char  = ochar_q;
	assign char_ch.last_char = olast_q;
endmodule

`default_nettype wire

[design/ihex_enc_buf.sv]
// record byte buffer: one write port, one registered read port
`default_nettype none

module ihex_enc_buf #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [7:0]         rd_data
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while the sequencer is stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

`default_nettype wire

[design/ihex_enc_chk.sv]
// port-level checks for the hex record encoder, bound to the top level
`default_nettype none

module ihex_enc_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cmd_ready,
	input wire logic       char_valid,
	input wire logic       char_ready,
	input wire logic [7:0] out_char,
	input wire logic       last_char
);
	// a stalled character beat holds
	a_char_hold: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_ready |=> char_valid && $stable(out_char) && $stable(last_char))
		else $error("character beat changed while stalled");

	// only hex digits, colon and newline are ever sent
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> ((out_char >= 8'h30 && out_char <= 8'h39) ||
			(out_char >= 8'h41 && out_char <= 8'h46) ||
			out_char == 8'h3A || out_char == 8'h0A))
		else $error("character outside the hex record alphabet");

	// a record start never closes a command
	a_colon_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && out_char == 8'h3A |-> !last_char)
		else $error("colon marked as last character");

	// while a command's text is still coming, no new command is taken
	a_busy_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !last_char |-> !cmd_ready)
		else $error("command taken before previous text finished");
endmodule

bind intel_hex_record_encoder ihex_enc_chk u_ihex_enc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_ready  (cmd_ch.ready),
	.char_valid (char_ch.valid),
	.char_ready (char_ch.ready),
	.out_char   (char_ch.out_char),
	.last_char  (char_ch.last_char)
);

`default_nettype wire
